// ===== hdl/ffea_pkg.sv =====
// shared constants, codes and types of the first-fit extent allocator
package ffea_pkg;

  localparam int unsigned FREE_SLOTS   = 16;
  localparam int unsigned HEADER_BYTES = 4;

  localparam int unsigned SLOT_W = $clog2(FREE_SLOTS);
  localparam int unsigned FILL_W = $clog2(FREE_SLOTS + 1);
  localparam int unsigned SIZE_W = 17;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned ENTRY_W = 2 * ADDR_W;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_INSIDE_FREE = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW    = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] placed_address;
    logic [1:0]        status;
    logic [ADDR_W-1:0] live_records;
  } res_t;

endpackage

// ===== hdl/ffea_if.sv =====
// request and response channel interfaces of the extent allocator
interface ffea_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] payload_length;
  logic [31:0] record_address;

  modport source (output valid, kind, payload_length, record_address, input ready);
  modport sink (input valid, kind, payload_length, record_address, output ready);
endinterface

interface ffea_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] placed_address;
  logic [1:0]  status;
  logic [31:0] live_records;

  modport source (output valid, placed_address, status, live_records, input ready);
  modport sink (input valid, placed_address, status, live_records, output ready);
endinterface

// ===== hdl/ffea_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
module ffea_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/ffea_ctrl.sv =====
// scan sequencer: walks the extent table, updates it and the counters
module ffea_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ffea_req_if.sink                      req_i,
  input  logic                          out_free_i,
  output logic                          res_push_o,
  output ffea_pkg::res_t                res_o,
  output logic                          ram_we_o,
  output logic [ffea_pkg::SLOT_W-1:0]   ram_waddr_o,
  output logic [ffea_pkg::ENTRY_W-1:0]  ram_wdata_o,
  output logic [ffea_pkg::SLOT_W-1:0]   ram_raddr_o,
  input  logic [ffea_pkg::ENTRY_W-1:0]  ram_rdata_i
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_PUSH = 2'd3;

  localparam logic [ffea_pkg::SLOT_W-1:0] LAST_SLOT =
    ffea_pkg::SLOT_W'(ffea_pkg::FREE_SLOTS - 1);
  localparam logic [ffea_pkg::FILL_W-1:0] FILL_FULL =
    ffea_pkg::FILL_W'(ffea_pkg::FREE_SLOTS);

  logic [1:0]                    state_q, state_d;
  logic [ffea_pkg::SLOT_W-1:0]   idx_q, idx_d;
  logic [ffea_pkg::FILL_W-1:0]   fill_q, fill_d;
  logic                          kind_q, kind_d;
  logic [ffea_pkg::SIZE_W-1:0]   size_q, size_d;
  logic [31:0]                   addr_q, addr_d;
  logic [31:0]                   append_q, append_d;
  logic [31:0]                   total_q, total_d;
  logic                          zero_found_q, zero_found_d;
  logic [ffea_pkg::SLOT_W-1:0]   zero_idx_q, zero_idx_d;
  ffea_pkg::res_t                res_q, res_d;

  logic [31:0] rd_start, rd_bytes, size_w, total_inc, total_dec, free_bytes;
  logic [32:0] ext_end, clip_sum, app_sum;
  logic        cur_valid, fit, addr_hit, last, table_full, free_slot_ok, accept;

  assign rd_start   = ram_rdata_i[ffea_pkg::ENTRY_W-1:ffea_pkg::ADDR_W];
  assign rd_bytes   = ram_rdata_i[ffea_pkg::ADDR_W-1:0];
  assign size_w     = 32'(size_q);
  assign cur_valid  = ffea_pkg::FILL_W'(idx_q) < fill_q;
  assign fit        = cur_valid && (rd_bytes >= size_w);
  assign ext_end    = {1'b0, rd_start} + {1'b0, rd_bytes};
  assign addr_hit   = cur_valid && (rd_start <= addr_q) && (ext_end > {1'b0, addr_q});
  assign last       = idx_q == LAST_SLOT;
  assign table_full = fill_q == FILL_FULL;
  assign free_slot_ok = !table_full || zero_found_q;
  assign total_inc  = (total_q == 32'hFFFF_FFFF) ? total_q : total_q + 32'd1;
  assign total_dec  = (total_q == 32'd0) ? total_q : total_q - 32'd1;
  assign clip_sum   = {1'b0, addr_q} + {1'b0, size_w};
  assign free_bytes = (clip_sum > 33'h1_0000_0000) ? (32'd0 - addr_q) : size_w;
  assign app_sum    = {1'b0, append_q} + {1'b0, size_w};

  assign req_i.ready = state_q == S_IDLE;
  assign accept      = req_i.valid && req_i.ready;
  assign ram_raddr_o = (state_q == S_IDLE) ? '0 : idx_q + ffea_pkg::SLOT_W'(1);
  assign res_push_o  = (state_q == S_PUSH) && out_free_i;
  assign res_o       = res_q;

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q;
    ram_wdata_o = {rd_start + size_w, rd_bytes - size_w};
    if (state_q == S_SCAN) begin
      ram_we_o = (kind_q == ffea_pkg::KIND_ALLOC) && fit;
    end else if (state_q == S_FIN && kind_q == ffea_pkg::KIND_FREE) begin
      ram_we_o    = free_slot_ok;
      ram_waddr_o = !table_full ? fill_q[ffea_pkg::SLOT_W-1:0] : zero_idx_q;
      ram_wdata_o = {addr_q, free_bytes};
    end
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    fill_d       = fill_q;
    kind_d       = kind_q;
    size_d       = size_q;
    addr_d       = addr_q;
    append_d     = append_q;
    total_d      = total_q;
    zero_found_d = zero_found_q;
    zero_idx_d   = zero_idx_q;
    res_d        = res_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d       = req_i.kind;
          size_d       = ffea_pkg::SIZE_W'(ffea_pkg::HEADER_BYTES)
                         + ffea_pkg::SIZE_W'(req_i.payload_length);
          addr_d       = req_i.record_address;
          idx_d        = '0;
          zero_found_d = 1'b0;
          state_d      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (kind_q == ffea_pkg::KIND_ALLOC && fit) begin
          res_d   = '{placed_address: rd_start, status: ffea_pkg::ST_OK,
                      live_records: total_inc};
          total_d = total_inc;
          state_d = S_PUSH;
        end else if (kind_q == ffea_pkg::KIND_FREE && addr_hit) begin
          res_d   = '{placed_address: 32'd0, status: ffea_pkg::ST_INSIDE_FREE,
                      live_records: total_q};
          state_d = S_PUSH;
        end else begin
          if (kind_q == ffea_pkg::KIND_FREE && cur_valid && rd_bytes == 32'd0
              && !zero_found_q) begin
            zero_found_d = 1'b1;
            zero_idx_d   = idx_q;
          end
          if (last) begin
            state_d = S_FIN;
          end else begin
            idx_d = idx_q + ffea_pkg::SLOT_W'(1);
          end
        end
      end
      S_FIN: begin
        state_d = S_PUSH;
        if (kind_q == ffea_pkg::KIND_ALLOC) begin
          if (app_sum[32]) begin
            res_d = '{placed_address: 32'd0, status: ffea_pkg::ST_OVERFLOW,
                      live_records: total_q};
          end else begin
            res_d    = '{placed_address: append_q, status: ffea_pkg::ST_OK,
                         live_records: total_inc};
            append_d = app_sum[31:0];
            total_d  = total_inc;
          end
        end else begin
          if (!table_full) begin
            fill_d = fill_q + ffea_pkg::FILL_W'(1);
          end
          res_d   = '{placed_address: 32'd0,
                      status: free_slot_ok ? ffea_pkg::ST_OK : ffea_pkg::ST_TABLE_FULL,
                      live_records: total_dec};
          total_d = total_dec;
        end
      end
      S_PUSH: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      append_q <= 32'(ffea_pkg::HEADER_BYTES);
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      append_q <= append_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    kind_q       <= kind_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    zero_found_q <= zero_found_d;
    zero_idx_q   <= zero_idx_d;
    res_q        <= res_d;
  end

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_SCAN && idx_q == '0)
    else $error("scan did not start at slot zero");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("fill count past table depth");

  a_fill_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fill_q >= $past(fill_q))
    else $error("slot released");

  a_append_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> append_q >= $past(append_q))
    else $error("append address went backward");

  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (state_q == S_SCAN && kind_q == ffea_pkg::KIND_ALLOC)
              || (state_q == S_FIN && kind_q == ffea_pkg::KIND_FREE))
    else $error("table write outside update step");

endmodule

// ===== hdl/first_fit_extent_allocator_unit.sv =====
// top level of the first-fit extent allocator: sequencer, extent table, result register
//
// req_i carries one word per record operation: kind (allocate or free), payload_length
// and record_address. rsp_o returns exactly one word per request: placed_address,
// status and live_records, in request order.
// A request is taken only while the sequencer is idle. It then reads the extent
// table, one slot per cycle, out of a single synchronous ram with registered read
// data, so the table depth sets the time per word.
// An allocate that hits a slot ends its scan there; a full scan (allocate miss, any
// free that is not rejected) reads every slot. The next request is taken once the
// sequencer has handed its result on and is idle again, so only one request is in
// the sequencer at a time.
// The result register parts the channels: when the receiver stalls, the result holds
// there and a new request is still taken and worked on; that request waits in its
// final step until the register is drained.
// Reset empties the table (no valid slot), sets the append address just past the
// count header and clears the live count; the table ram itself needs no clearing.
module first_fit_extent_allocator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffea_req_if.sink  req_i,
  ffea_rsp_if.source rsp_o
);

  logic                          res_push;
  ffea_pkg::res_t                res, out_q, out_d;
  logic                          out_valid_q, out_valid_d, out_free;
  logic                          ram_we;
  logic [ffea_pkg::SLOT_W-1:0]   ram_waddr, ram_raddr;
  logic [ffea_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

  assign out_free = !out_valid_q || rsp_o.ready;

  ffea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .out_free_i  (out_free),
    .res_push_o  (res_push),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ffea_ram #(
    .Width (ffea_pkg::ENTRY_W),
    .Depth (ffea_pkg::FREE_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_push) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.placed_address = out_q.placed_address;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.live_records   = out_q.live_records;

endmodule

// ===== sim/first_fit_extent_allocator_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench of the first-fit extent allocator: directed, stalled-receiver, random and large-record runs
module first_fit_extent_allocator_unit_tb;

  typedef struct {
    logic [31:0] addr;
    logic [15:0] plen;
  } rec_t;

  logic clk_i;
  logic rst_ni;

  ffea_req_if req_bus ();
  ffea_rsp_if rsp_bus ();

  first_fit_extent_allocator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  logic [31:0] ext_start [ffea_pkg::FREE_SLOTS];
  logic [31:0] ext_bytes [ffea_pkg::FREE_SLOTS];
  bit          ext_used  [ffea_pkg::FREE_SLOTS];
  logic [31:0] append_ptr;
  logic [31:0] live_count;

  ffea_pkg::res_t expected_rsp [$];
  rec_t           live_recs [$];
  int             mismatches;
  bit             idle_on;
  int             rsp_hold;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic ffea_pkg::res_t predict_result(logic kind, logic [15:0] plen,
                                                    logic [31:0] addr);
    ffea_pkg::res_t r;
    logic [32:0]    rec_size;
    logic [32:0]    room;
    int             hit;
    r = '0;
    hit = -1;
    rec_size = 33'(ffea_pkg::HEADER_BYTES) + 33'(plen);
    if (kind == ffea_pkg::KIND_ALLOC) begin
      for (int i = 0; i < ffea_pkg::FREE_SLOTS; i++)
        if (hit < 0 && ext_used[i] && {1'b0, ext_bytes[i]} >= rec_size) hit = i;
      if (hit >= 0) begin
        r.placed_address = ext_start[hit];
        r.status = ffea_pkg::ST_OK;
        ext_start[hit] = ext_start[hit] + rec_size[31:0];
        ext_bytes[hit] = ext_bytes[hit] - rec_size[31:0];
        if (live_count != 32'hFFFF_FFFF) live_count++;
      end else if ({1'b0, append_ptr} + rec_size > 33'h0_FFFF_FFFF) begin
        r.status = ffea_pkg::ST_OVERFLOW;
      end else begin
        r.placed_address = append_ptr;
        r.status = ffea_pkg::ST_OK;
        append_ptr = append_ptr + rec_size[31:0];
        if (live_count != 32'hFFFF_FFFF) live_count++;
      end
    end else begin
      for (int i = 0; i < ffea_pkg::FREE_SLOTS; i++)
        if (ext_used[i] && ext_start[i] <= addr &&
            {1'b0, ext_start[i]} + {1'b0, ext_bytes[i]} > {1'b0, addr}) hit = -2;
      if (hit == -2) begin
        r.status = ffea_pkg::ST_INSIDE_FREE;
      end else begin
        room = 33'h1_0000_0000 - {1'b0, addr};
        if (rec_size > room) rec_size = room;
        for (int i = 0; i < ffea_pkg::FREE_SLOTS; i++)
          if (hit < 0 && !ext_used[i]) hit = i;
        for (int i = 0; i < ffea_pkg::FREE_SLOTS; i++)
          if (hit < 0 && ext_bytes[i] == 0) hit = i;
        if (hit < 0) begin
          r.status = ffea_pkg::ST_TABLE_FULL;
        end else begin
          ext_used[hit] = 1'b1;
          ext_start[hit] = addr;
          ext_bytes[hit] = rec_size[31:0];
          r.status = ffea_pkg::ST_OK;
        end
        if (live_count != 0) live_count--;
      end
    end
    r.live_records = live_count;
    return r;
  endfunction

  task automatic send_word(input logic kind, input logic [15:0] plen,
                           input logic [31:0] addr, output ffea_pkg::res_t r);
    rec_t rec;
    while (idle_on && $urandom_range(99) < 18) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid          <= 1'b1;
    req_bus.kind           <= kind;
    req_bus.payload_length <= plen;
    req_bus.record_address <= addr;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    r = predict_result(kind, plen, addr);
    expected_rsp = {expected_rsp, r};
    if (kind == ffea_pkg::KIND_ALLOC && r.status == ffea_pkg::ST_OK) begin
      rec.addr = r.placed_address;
      rec.plen = plen;
      live_recs = {live_recs, rec};
    end
  endtask

  task automatic free_live(input int idx, input bit bad_len);
    ffea_pkg::res_t r;
    rec_t           rec;
    logic [15:0]    plen;
    rec = live_recs[idx];
    live_recs.delete(idx);
    plen = bad_len ? 16'($urandom) : rec.plen;
    send_word(ffea_pkg::KIND_FREE, plen, rec.addr, r);
  endtask

  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return 16'((1 << $urandom_range(6)) * 4 - 4);
    if (sel < 80) return 16'($urandom_range(255));
    return 16'($urandom_range(65535));
  endfunction

  // response checker
  always @(posedge clk_i) begin
    ffea_pkg::res_t want;
    if (rst_ni && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: placed %h status %0d live %0d",
                   rsp_bus.placed_address, rsp_bus.status, rsp_bus.live_records);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp_bus.placed_address !== want.placed_address ||
            rsp_bus.status !== want.status ||
            rsp_bus.live_records !== want.live_records) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp placed %h status %0d live %0d, got %h %0d %0d",
                     want.placed_address, want.status, want.live_records,
                     rsp_bus.placed_address, rsp_bus.status, rsp_bus.live_records);
        end
      end
    end
  end

  // receiver stall control
  always @(posedge clk_i) begin
    if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= !(idle_on && $urandom_range(99) < 18);
    end
  end

  task automatic test_directed();
    ffea_pkg::res_t r;
    // free with no live record, free running past the top, free inside a free extent
    send_word(ffea_pkg::KIND_FREE, 16'h0000, 32'h0000_0100, r);
    send_word(ffea_pkg::KIND_FREE, 16'hFFFF, 32'hFFFF_FFFF, r);
    send_word(ffea_pkg::KIND_FREE, 16'h0005, 32'h0000_0102, r);
    send_word(ffea_pkg::KIND_ALLOC, 16'h0000, 32'hFFFF_FFFF, r);
    send_word(ffea_pkg::KIND_ALLOC, 16'hFFFF, 32'h0000_0000, r);
    send_word(ffea_pkg::KIND_ALLOC, 16'h0000, 32'h0000_0000, r);
    send_word(ffea_pkg::KIND_ALLOC, 16'd1234, 32'h5555_5555, r);
    free_live(1, 1'b0);
    send_word(ffea_pkg::KIND_ALLOC, 16'd100, 32'h0, r);
    send_word(ffea_pkg::KIND_FREE, 16'h5555, 32'hAAAA_AAAA, r);
    send_word(ffea_pkg::KIND_FREE, 16'hAAAA, 32'h5555_5555, r);
    send_word(ffea_pkg::KIND_FREE, 16'h0000, 32'h0000_0000, r);
    // fill the table until a free is dropped
    for (int i = 0; i < 24; i++) begin
      send_word(ffea_pkg::KIND_FREE, 16'd8, 32'h4000_0000 + 32'(i) * 32'h1000, r);
      if (r.status == ffea_pkg::ST_TABLE_FULL) break;
    end
    wait_drained();
  endtask

  task automatic test_stall_fill();
    ffea_pkg::res_t r;
    rsp_hold = 150;
    repeat (10) send_word(ffea_pkg::KIND_ALLOC, pick_len(), 32'($urandom), r);
    wait_drained();
  endtask

  task automatic test_random(input int n);
    ffea_pkg::res_t r;
    int             sel;
    int             k;
    logic [31:0]    addr;
    idle_on = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i == n / 4) idle_on = 1'b0;
      if (i == n / 4 + 120) idle_on = 1'b1;
      if (i == n / 2) begin
        wait_drained();
        rsp_hold = 100;
      end
      sel = $urandom_range(99);
      k = $urandom_range(ffea_pkg::FREE_SLOTS - 1);
      if (sel < 50 || live_recs.size() == 0) begin
        send_word(ffea_pkg::KIND_ALLOC, pick_len(), 32'($urandom), r);
      end else if (sel < 85) begin
        free_live($urandom_range(live_recs.size() - 1), $urandom_range(9) == 0);
      end else if (sel < 93 || !ext_used[k] || ext_bytes[k] == 0) begin
        send_word(ffea_pkg::KIND_FREE, 16'($urandom), 32'($urandom), r);
      end else begin
        addr = ext_start[k] + 32'($urandom_range(ext_bytes[k] - 1));
        send_word(ffea_pkg::KIND_FREE, pick_len(), addr, r);
      end
    end
    wait_drained();
    idle_on = 1'b0;
  endtask

  task automatic test_large_alloc();
    ffea_pkg::res_t r;
    idle_on = 1'b0;
    repeat (40) send_word(ffea_pkg::KIND_ALLOC, 16'hFFFF, 32'($urandom), r);
    send_word(ffea_pkg::KIND_ALLOC, 16'h0000, 32'h0, r);
    if (live_recs.size() != 0) free_live(live_recs.size() - 1, 1'b0);
    send_word(ffea_pkg::KIND_ALLOC, 16'hFFFF, 32'h0, r);
    send_word(ffea_pkg::KIND_ALLOC, 16'h0000, 32'h0, r);
    wait_drained();
  endtask

  initial begin
    req_bus.valid          = 1'b0;
    req_bus.kind           = ffea_pkg::KIND_ALLOC;
    req_bus.payload_length = '0;
    req_bus.record_address = '0;
    rsp_bus.ready          = 1'b0;
    rst_ni                 = 1'b0;
    idle_on                = 1'b0;
    rsp_hold               = 0;
    mismatches             = 0;
    for (int i = 0; i < ffea_pkg::FREE_SLOTS; i++) begin
      ext_used[i]  = 1'b0;
      ext_start[i] = '0;
      ext_bytes[i] = '0;
    end
    append_ptr = ffea_pkg::HEADER_BYTES;
    live_count = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_stall_fill();
    test_random(1500);
    test_large_alloc();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && expected_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #32_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/ffea_pkg.sv
hdl/ffea_if.sv
hdl/ffea_ram.sv
hdl/ffea_ctrl.sv
hdl/first_fit_extent_allocator_unit.sv
sim/first_fit_extent_allocator_unit_tb.sv
